@@ sv/aard_pkg.sv @@
// shared types, codes and microcode program of the accumulator calculator
`default_nettype none
package aard_pkg;

  localparam int CNT_W  = 32;
  localparam int OP_W   = 3;
  localparam int MODE_W = 2;
  localparam int ST_W   = 2;
  localparam int UA_W   = 4;

  localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_ROUND   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CUT     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISCARD = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [ST_W-1:0] ST_DISCARD  = 2'd2;

  // microcode addresses
  localparam logic [UA_W-1:0] UA_FETCH    = 4'd0;
  localparam logic [UA_W-1:0] UA_DISPATCH = 4'd1;
  localparam logic [UA_W-1:0] UA_LOAD     = 4'd2;
  localparam logic [UA_W-1:0] UA_ADD      = 4'd3;
  localparam logic [UA_W-1:0] UA_SUB      = 4'd4;
  localparam logic [UA_W-1:0] UA_MUL_INIT = 4'd5;
  localparam logic [UA_W-1:0] UA_MUL_STEP = 4'd6;
  localparam logic [UA_W-1:0] UA_MUL_WR   = 4'd7;
  localparam logic [UA_W-1:0] UA_DIV_INIT = 4'd8;
  localparam logic [UA_W-1:0] UA_DIV_STEP = 4'd9;
  localparam logic [UA_W-1:0] UA_DIV_RND  = 4'd10;
  localparam logic [UA_W-1:0] UA_DIV_SGN  = 4'd11;
  localparam logic [UA_W-1:0] UA_WB_CNT   = 4'd12;
  localparam logic [UA_W-1:0] UA_WB_OK    = 4'd13;
  localparam logic [UA_W-1:0] UA_WB_DZ    = 4'd14;
  localparam logic [UA_W-1:0] UA_WB_DISC  = 4'd15;

  typedef enum logic [3:0] {
    U_NOP,
    U_LOAD,
    U_ADD,
    U_SUB,
    U_MUL_INIT,
    U_MUL_STEP,
    U_MUL_WR,
    U_DIV_INIT,
    U_DIV_STEP,
    U_DIV_RND,
    U_DIV_SGN,
    U_WB
  } uop_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_IN,
    C_DISPATCH,
    C_MORE,
    C_BZERO,
    C_DISCARD,
    C_HOLD_OUT
  } cond_t;

  typedef struct packed {
    uop_t            uop;
    logic            cnt;
    logic [ST_W-1:0] st;
    cond_t           cond;
    logic [UA_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            more;
    logic            bzero;
    logic            discard;
    logic            out_busy;
  } flags_t;

  function automatic ctrl_t ucode(input logic [UA_W-1:0] addr);
    ctrl_t cw;
    cw = '{uop: U_NOP, cnt: 1'b0, st: ST_OK, cond: C_NEXT, target: UA_FETCH};
    case (addr)
      UA_FETCH:    cw.cond = C_WAIT_IN;
      UA_DISPATCH: cw.cond = C_DISPATCH;
      UA_LOAD:     begin cw.uop = U_LOAD; cw.cond = C_JUMP; cw.target = UA_WB_OK; end
      UA_ADD:      begin cw.uop = U_ADD; cw.cond = C_JUMP; cw.target = UA_WB_CNT; end
      UA_SUB:      begin cw.uop = U_SUB; cw.cond = C_JUMP; cw.target = UA_WB_CNT; end
      UA_MUL_INIT: cw.uop = U_MUL_INIT;
      UA_MUL_STEP: begin cw.uop = U_MUL_STEP; cw.cond = C_MORE; cw.target = UA_MUL_STEP; end
      UA_MUL_WR:   begin cw.uop = U_MUL_WR; cw.cond = C_JUMP; cw.target = UA_WB_CNT; end
      UA_DIV_INIT: begin cw.uop = U_DIV_INIT; cw.cond = C_BZERO; cw.target = UA_WB_DZ; end
      UA_DIV_STEP: begin cw.uop = U_DIV_STEP; cw.cond = C_MORE; cw.target = UA_DIV_STEP; end
      UA_DIV_RND:  begin cw.uop = U_DIV_RND; cw.cond = C_DISCARD; cw.target = UA_WB_DISC; end
      UA_DIV_SGN:  begin cw.uop = U_DIV_SGN; cw.cond = C_JUMP; cw.target = UA_WB_CNT; end
      UA_WB_CNT:   begin cw.uop = U_WB; cw.cnt = 1'b1; cw.cond = C_HOLD_OUT; end
      UA_WB_OK:    begin cw.uop = U_WB; cw.cond = C_HOLD_OUT; end
      UA_WB_DZ:    begin cw.uop = U_WB; cw.st = ST_DIV_ZERO; cw.cond = C_HOLD_OUT; end
      UA_WB_DISC:  begin cw.uop = U_WB; cw.st = ST_DISCARD; cw.cond = C_HOLD_OUT; end
      default:     cw.cond = C_JUMP;
    endcase
    return cw;
  endfunction

  function automatic logic [UA_W-1:0] dispatch(input logic [OP_W-1:0] op);
    logic [UA_W-1:0] a;
    case (op)
      OP_LOAD: a = UA_LOAD;
      OP_ADD:  a = UA_ADD;
      OP_SUB:  a = UA_SUB;
      OP_MUL:  a = UA_MUL_INIT;
      OP_DIV:  a = UA_DIV_INIT;
      default: a = UA_WB_OK;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ sv/accumulator_alu_rounding_divide.sv @@
// top level of the microcoded signed accumulator calculator
//
//  channel | direction | handshake           | tdata fields (low bit first)
//  in_     | input     | in_tvalid/in_tready | opcode, operand, div_mode
//  out_    | output    | out_tvalid/tready   | acc_value, positive_count,
//          |           |                     | negative_count, status
//
//  load/add/sub: dispatch, execute, writeback; unknown opcodes skip execute
//  multiply: init, one shift-add step per cycle, write, writeback
//  divide: init, steps, round, sign, writeback; div-zero, discard end early
//  a new item is taken as soon as the sequencer returns to fetch, even while
//  the last result still sits in the output register; writeback waits on it
//  synchronous active-low reset clears accumulator, counters and output valid
`default_nettype none
module accumulator_alu_rounding_divide #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // opcode, operand, div_mode
  input  wire logic [((DATA_WIDTH+12)/8)*8-1:0] in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // acc_value, positive_count, negative_count, status
  output logic [((DATA_WIDTH+73)/8)*8-1:0]     out_tdata
);

  localparam int DW    = DATA_WIDTH;
  localparam int OUT_W = ((DATA_WIDTH + 73) / 8) * 8;
  localparam int OPW   = aard_pkg::OP_W;
  localparam int MW    = aard_pkg::MODE_W;
  localparam int CW    = aard_pkg::CNT_W;
  localparam int ST_LO = DW + 2 * CW;

  aard_pkg::ctrl_t  ctrl;
  aard_pkg::flags_t flags;
  logic             idle;
  logic             in_accept;

  assign in_tready = idle;
  assign in_accept = in_tvalid && idle;

  aard_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .flags     (flags),
    .ctrl      (ctrl),
    .idle      (idle)
  );

  aard_dp #(
    .DATA_WIDTH (DW),
    .OUT_W      (OUT_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_op      (in_tdata[OPW-1:0]),
    .in_operand (in_tdata[OPW+DW-1:OPW]),
    .in_mode    (in_tdata[OPW+DW+MW-1:OPW+DW]),
    .ctrl       (ctrl),
    .flags      (flags),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  // the block is busy right after taking an item
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n) (in_tvalid && in_tready) |=> !in_tready
  ) else $error("item accepted while previous item still in work");

  // a fresh result only follows a cycle in which the sequencer was working
  a_result_after_work: assert property (
    @(posedge clk) disable iff (!rst_n) $rose(out_tvalid) |-> $past(!in_tready)
  ) else $error("result appeared without an item in work");

  // status code is never the unused value
  a_status_code: assert property (
    @(posedge clk) disable iff (!rst_n)
      out_tvalid |-> (out_tdata[ST_LO+1:ST_LO] != 2'd3)
  ) else $error("unused status code on result");

endmodule
`default_nettype wire

@@ sv/aard_seq.sv @@
// microcode sequencer: step counter, program table lookup and jump logic
`default_nettype none
module aard_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  input  aard_pkg::flags_t     flags,
  output aard_pkg::ctrl_t      ctrl,
  output logic                 idle
);

  logic [aard_pkg::UA_W-1:0] upc_r;
  logic [aard_pkg::UA_W-1:0] upc_nxt;
  logic [aard_pkg::UA_W-1:0] upc_inc;

  assign ctrl    = aard_pkg::ucode(upc_r);
  assign idle    = (upc_r == aard_pkg::UA_FETCH);
  assign upc_inc = upc_r + aard_pkg::UA_W'(1);

  always_comb begin
    upc_nxt = upc_inc;
    case (ctrl.cond)
      aard_pkg::C_NEXT:     upc_nxt = upc_inc;
      aard_pkg::C_JUMP:     upc_nxt = ctrl.target;
      aard_pkg::C_WAIT_IN:  upc_nxt = in_tvalid ? upc_inc : upc_r;
      aard_pkg::C_DISPATCH: upc_nxt = aard_pkg::dispatch(flags.op);
      aard_pkg::C_MORE:     upc_nxt = flags.more ? ctrl.target : upc_inc;
      aard_pkg::C_BZERO:    upc_nxt = flags.bzero ? ctrl.target : upc_inc;
      aard_pkg::C_DISCARD:  upc_nxt = flags.discard ? ctrl.target : upc_inc;
      aard_pkg::C_HOLD_OUT: upc_nxt = flags.out_busy ? upc_r : ctrl.target;
      default:              upc_nxt = aard_pkg::UA_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= aard_pkg::UA_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/aard_dp.sv @@
// datapath: accumulator, shift-add multiply, restoring divide, counters, output register
`default_nettype none
module aard_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int OUT_W      = 104
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_accept,
  input  wire logic [aard_pkg::OP_W-1:0]     in_op,
  input  wire logic [DATA_WIDTH-1:0]         in_operand,
  input  wire logic [aard_pkg::MODE_W-1:0]   in_mode,
  input  aard_pkg::ctrl_t                    ctrl,
  output aard_pkg::flags_t                   flags,
  input  wire logic                          out_tready,
  output logic                               out_tvalid,
  output logic [OUT_W-1:0]                   out_tdata
);

  localparam int DW  = DATA_WIDTH;
  localparam int ITW = $clog2(DW + 1);
  localparam int CW  = aard_pkg::CNT_W;

  logic [DW-1:0]                 acc_r, acc_nxt;
  logic [CW-1:0]                 pos_r, pos_nxt;
  logic [CW-1:0]                 neg_r, neg_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]              out_data_r, out_data_nxt;
  logic [DW-1:0]                 opnd_r;
  logic [aard_pkg::OP_W-1:0]     op_r;
  logic [aard_pkg::MODE_W-1:0]   mode_r;
  logic [DW-1:0]                 wk_r, wk_nxt;
  logic [DW-1:0]                 sh_r, sh_nxt;
  logic [DW-1:0]                 dvs_r, dvs_nxt;
  logic                          qneg_r, qneg_nxt;
  logic [ITW-1:0]                it_r, it_nxt;

  logic [DW-1:0]                 acc_mag;
  logic [DW-1:0]                 opnd_mag;
  logic [DW-1:0]                 mul_sum;
  logic [DW:0]                   div_shift;
  logic [DW:0]                   div_trial;
  logic                          rem_nz;
  logic                          rnd;
  logic                          out_busy;
  logic                          wb_go;
  logic [CW-1:0]                 pos_bump;
  logic [CW-1:0]                 neg_bump;

  assign acc_mag   = acc_r[DW-1] ? (~acc_r + DW'(1)) : acc_r;
  assign opnd_mag  = opnd_r[DW-1] ? (~opnd_r + DW'(1)) : opnd_r;
  assign mul_sum   = {wk_r[DW-2:0], 1'b0} + (sh_r[DW-1] ? acc_r : '0);
  assign div_shift = {wk_r, sh_r[DW-1]};
  assign div_trial = div_shift - {1'b0, dvs_r};
  assign rem_nz    = |wk_r;
  assign rnd       = (mode_r == aard_pkg::MODE_ROUND) && rem_nz &&
                     ({wk_r, 1'b0} >= {1'b0, dvs_r});
  assign out_busy  = out_valid_r && !out_tready;
  assign wb_go     = (ctrl.uop == aard_pkg::U_WB) && !out_busy;
  assign pos_bump  = (&pos_r) ? pos_r : pos_r + CW'(1);
  assign neg_bump  = (&neg_r) ? neg_r : neg_r + CW'(1);

  assign flags.op       = op_r;
  assign flags.more     = (it_r != ITW'(1));
  assign flags.bzero    = (opnd_r == '0);
  assign flags.discard  = rem_nz && (mode_r == aard_pkg::MODE_DISCARD);
  assign flags.out_busy = out_busy;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    neg_nxt  = neg_r;
    wk_nxt   = wk_r;
    sh_nxt   = sh_r;
    dvs_nxt  = dvs_r;
    qneg_nxt = qneg_r;
    it_nxt   = it_r;
    case (ctrl.uop)
      aard_pkg::U_LOAD: begin
        acc_nxt = opnd_r;
        pos_nxt = '0;
        neg_nxt = '0;
      end
      aard_pkg::U_ADD: acc_nxt = acc_r + opnd_r;
      aard_pkg::U_SUB: acc_nxt = acc_r - opnd_r;
      aard_pkg::U_MUL_INIT: begin
        wk_nxt = '0;
        sh_nxt = opnd_r;
        it_nxt = ITW'(DW);
      end
      aard_pkg::U_MUL_STEP: begin
        wk_nxt = mul_sum;
        sh_nxt = {sh_r[DW-2:0], 1'b0};
        it_nxt = it_r - ITW'(1);
      end
      aard_pkg::U_MUL_WR: acc_nxt = wk_r;
      aard_pkg::U_DIV_INIT: begin
        wk_nxt   = '0;
        sh_nxt   = acc_mag;
        dvs_nxt  = opnd_mag;
        qneg_nxt = acc_r[DW-1] ^ opnd_r[DW-1];
        it_nxt   = ITW'(DW);
      end
      aard_pkg::U_DIV_STEP: begin
        if (!div_trial[DW]) begin
          wk_nxt = div_trial[DW-1:0];
          sh_nxt = {sh_r[DW-2:0], 1'b1};
        end else begin
          wk_nxt = div_shift[DW-1:0];
          sh_nxt = {sh_r[DW-2:0], 1'b0};
        end
        it_nxt = it_r - ITW'(1);
      end
      aard_pkg::U_DIV_RND: sh_nxt = sh_r + DW'(rnd);
      aard_pkg::U_DIV_SGN: acc_nxt = qneg_r ? (~sh_r + DW'(1)) : sh_r;
      aard_pkg::U_WB: begin
        if (wb_go && ctrl.cnt) begin
          if (acc_r[DW-1]) begin
            neg_nxt = neg_bump;
          end else begin
            pos_nxt = pos_bump;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (wb_go) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[DW-1:0]                     = acc_r;
      out_data_nxt[DW+CW-1:DW]                 = pos_nxt;
      out_data_nxt[DW+2*CW-1:DW+CW]            = neg_nxt;
      out_data_nxt[DW+2*CW+aard_pkg::ST_W-1:DW+2*CW] = ctrl.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      pos_r       <= '0;
      neg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_op;
      opnd_r <= in_operand;
      mode_r <= in_mode;
    end
    wk_r       <= wk_nxt;
    sh_r       <= sh_nxt;
    dvs_r      <= dvs_nxt;
    qneg_r     <= qneg_nxt;
    it_r       <= it_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire
